### rtl/tcache_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tile cache.
package tcache_pkg;

  localparam int KEY_W   = 32;
  localparam int STAMP_W = 31;
  localparam int SLOT_W  = 6;

  // One stored slot: both grid coordinates and the last-access stamp.
  typedef struct packed {
    logic [KEY_W-1:0]   key_x;
    logic [KEY_W-1:0]   key_z;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DELIVER
  } tcache_state_t;

endpackage

### rtl/tcache_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the tile cache.
interface tcache_req_if
  import tcache_pkg::*;
  (input logic clk);
  logic                      valid;
  logic                      ready;
  logic signed [KEY_W-1:0]   key_x;
  logic signed [KEY_W-1:0]   key_z;
  logic        [STAMP_W-1:0] tick;

  modport source (output valid, key_x, key_z, tick, input ready);
  modport sink   (input valid, key_x, key_z, tick, output ready);
endinterface

interface tcache_rsp_if
  import tcache_pkg::*;
  (input logic clk);
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted;
  logic              fill_request;

  modport source (output valid, hit, slot, evicted, fill_request, input ready);
  modport sink   (input valid, hit, slot, evicted, fill_request, output ready);
endinterface

### rtl/tcache_slot_mem.sv
`timescale 1ns / 1ps
// Synchronous slot memory: one write port and one registered read port.
module tcache_slot_mem
  import tcache_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int IDX_W     = 6
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  rd_addr,
  output slot_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  slot_entry_t       wr_data
);

  slot_entry_t mem [NUM_SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: rd_data shows the addressed slot in the next cycle.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/tcache_ctrl.sv
`timescale 1ns / 1ps
// Scan sequencer: key match, oldest-stamp search, write-back and result register.
module tcache_ctrl
  import tcache_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic              clk,
  input  logic              rst,
  tcache_req_if.sink        req,
  tcache_rsp_if.source      rsp,
  output logic [IDX_W-1:0]  rd_addr,
  input  slot_entry_t       rd_data,
  output logic              wr_en,
  output logic [IDX_W-1:0]  wr_addr,
  output slot_entry_t       wr_data
);

  tcache_state_t state, state_next;

  logic [CNT_W-1:0]   slots_used;
  logic [KEY_W-1:0]   key_x;
  logic [KEY_W-1:0]   key_z;
  logic [STAMP_W-1:0] tick;
  logic [IDX_W-1:0]   cmp_idx;
  logic [IDX_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_stamp;
  logic [IDX_W-1:0]   target;
  logic               res_hit;
  logic               res_evicted;

  logic               out_valid;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_evicted;
  logic               out_fill;

  logic req_fire;
  logic full;
  logic key_match;
  logic last_cmp;
  logic cand_less;
  logic scan_done;
  logic out_free;

  assign req_fire  = req.valid && req.ready;
  assign full      = (slots_used == CNT_W'(NUM_SLOTS));
  assign key_match = (rd_data.key_x == key_x) && (rd_data.key_z == key_z);
  assign last_cmp  = (CNT_W'(cmp_idx) == slots_used - CNT_W'(1));
  // The first slot compared always seeds the oldest-stamp search.
  assign cand_less = (cmp_idx == '0) || (rd_data.stamp < best_stamp);
  assign scan_done = key_match || last_cmp;
  assign out_free  = !out_valid || rsp.ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = (slots_used == '0) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    req.ready = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_SCAN: begin
        if (cmp_idx != IDX_W'(NUM_SLOTS - 1)) begin
          rd_addr = cmp_idx + IDX_W'(1);
        end
      end
      ST_WRITE: begin
        wr_en = 1'b1;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign wr_addr = target;
  assign wr_data = '{key_x: key_x, key_z: key_z, stamp: tick};

  // State and occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slots_used <= '0;
    end else begin
      state <= state_next;
      if (state == ST_WRITE && !res_hit && !full) begin
        slots_used <= slots_used + CNT_W'(1);
      end
    end
  end

  // Request capture, scan bookkeeping and slot choice.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_fire) begin
      key_x       <= req.key_x;
      key_z       <= req.key_z;
      tick        <= req.tick;
      cmp_idx     <= '0;
      target      <= '0;
      res_hit     <= 1'b0;
      res_evicted <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (cand_less) begin
        best_idx   <= cmp_idx;
        best_stamp <= rd_data.stamp;
      end
      if (key_match) begin
        target      <= cmp_idx;
        res_hit     <= 1'b1;
        res_evicted <= 1'b0;
      end else if (last_cmp) begin
        res_hit     <= 1'b0;
        res_evicted <= full;
        if (full) begin
          target <= cand_less ? cmp_idx : best_idx;
        end else begin
          target <= slots_used[IDX_W-1:0];
        end
      end else begin
        cmp_idx <= cmp_idx + IDX_W'(1);
      end
    end
  end

  // Result register: holds one finished result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DELIVER && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DELIVER && out_free) begin
      out_hit     <= res_hit;
      out_slot    <= SLOT_W'(target);
      out_evicted <= res_evicted;
      out_fill    <= !res_hit;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.slot         = out_slot;
  assign rsp.evicted      = out_evicted;
  assign rsp.fill_request = out_fill;

  // The occupancy count never passes the number of slots.
  assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(NUM_SLOTS))
    else $error("slot occupancy count overflowed");

  // The scan only compares occupied slots.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CNT_W'(cmp_idx) < slots_used))
    else $error("scan index beyond occupied slots");

  // A write-back is always followed by delivery of the result.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (state == ST_DELIVER))
    else $error("write-back not followed by delivery");

  // A delivery step with a free result register always loads a new result.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DELIVER && out_free) |=> out_valid)
    else $error("result register not loaded on delivery");

endmodule

### rtl/tile_cache_lru_timestamp.sv
`timescale 1ns / 1ps
// Top level of the fully associative tile cache with stamp-based LRU replacement.
//
// Each request on the req channel carries a tile key (key_x, key_z) and the
// current tick. The rsp channel returns one result per request: hit, the slot
// that now holds the key, evicted and fill_request. A miss takes the next free
// slot while any remain, otherwise the slot with the oldest stamp, the lowest
// index winning a tie.
// Slot keys and stamps live in one synchronous memory. A request is served by
// reading the occupied slots one per cycle, comparing the key and tracking the
// oldest stamp, and then writing the chosen slot back. The result then passes
// through the delivery step into the output register, where it becomes valid.
// Up to NUM_SLOTS slots are read per request, fewer on an early hit and none
// while the cache is empty. One request is in service at a time, so a new
// request is taken only after the previous result has entered the output
// register.
// The finished result sits in an output register, so a new request is taken
// while the previous result still waits; a stalled receiver holds the block
// only when a second result is ready to be delivered.
// Reset clears the occupancy count, the sequencer and the output valid flag;
// the memory is not cleared, as only occupied slots are ever compared.
module tile_cache_lru_timestamp
  import tcache_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  tcache_req_if.sink   req,
  tcache_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [IDX_W-1:0] rd_addr;
  slot_entry_t      rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_entry_t      wr_data;

  // Slot storage.
  tcache_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Scan sequencer and result register.
  tcache_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

### test/tcache_access_checker.sv
`timescale 1ns / 1ps
// Checker for the tile cache: tracks the slot contents and compares every response.
module tcache_access_checker
  import tcache_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic  clk,
  input  logic  rst,
  tcache_req_if req,
  tcache_rsp_if rsp,
  output int    mismatches,
  output int    pending,
  output int    hits,
  output int    fills,
  output int    evictions
);

  // One response as the receiver sees it.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic              fill_request;
  } access_result_t;

  slot_entry_t    shadow_slots [NUM_SLOTS];
  int             slots_taken;
  access_result_t pending_results[$];
  int             err_count;
  int             hit_count;
  int             fill_count;
  int             evict_count;

  // Looks the key up in the shadow slots, updates them as the cache would and
  // returns the response that the access must produce.
  function automatic access_result_t lookup_and_update(input logic [KEY_W-1:0] kx,
                                                       input logic [KEY_W-1:0] kz,
                                                       input logic [STAMP_W-1:0] tk);
    access_result_t r;
    int             victim;
    r = '0;
    for (int i = 0; i < slots_taken; i++) begin
      if (shadow_slots[i].key_x == kx && shadow_slots[i].key_z == kz) begin
        shadow_slots[i].stamp = tk;
        r.hit  = 1'b1;
        r.slot = SLOT_W'(i);
        return r;
      end
    end
    if (slots_taken < NUM_SLOTS) begin
      victim      = slots_taken;
      slots_taken = slots_taken + 1;
    end else begin
      // Oldest stamp wins; strict comparison keeps the lowest index on a tie.
      victim = 0;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (shadow_slots[i].stamp < shadow_slots[victim].stamp) victim = i;
      end
      r.evicted = 1'b1;
    end
    shadow_slots[victim] = '{key_x: kx, key_z: kz, stamp: tk};
    r.slot         = SLOT_W'(victim);
    r.fill_request = 1'b1;
    return r;
  endfunction

  // Responses are checked before the request of the same edge is predicted,
  // since a response can never belong to a request accepted at that edge.
  always @(posedge clk) begin
    access_result_t want;
    access_result_t got;
    access_result_t predicted;
    if (rst) begin
      slots_taken = 0;
      pending_results.delete();
      err_count   = 0;
      hit_count   = 0;
      fill_count  = 0;
      evict_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{hit: rsp.hit, slot: rsp.slot, evicted: rsp.evicted,
                fill_request: rsp.fill_request};
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: response with nothing outstanding: %s%0d %s%0d %s%0d %s%0d",
                     $realtime, "hit=", got.hit, "slot=", got.slot,
                     "evicted=", got.evicted, "fill=", got.fill_request);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: mismatch: expected hit=%0d slot=%0d evicted=%0d fill=%0d,",
                       $realtime, want.hit, want.slot, want.evicted, want.fill_request);
              $display("  got hit=%0d slot=%0d evicted=%0d fill=%0d",
                       got.hit, got.slot, got.evicted, got.fill_request);
            end
          end
          if (want.hit) hit_count++;
          if (want.fill_request) fill_count++;
          if (want.evicted) evict_count++;
        end
      end
      if (req.valid && req.ready) begin
        predicted       = lookup_and_update(req.key_x, req.key_z, req.tick);
        pending_results = {pending_results, predicted};
      end
    end
    mismatches <= err_count;
    pending    <= pending_results.size();
    hits       <= hit_count;
    fills      <= fill_count;
    evictions  <= evict_count;
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Top of the tile cache testbench: clock, reset, request and response traffic, verdict.
module tb_top;
  import tcache_pkg::*;

  localparam int NUM_SLOTS    = 64;
  localparam int CLK_PERIOD   = 4;
  localparam int LONG_STALL   = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int HIST_DEPTH   = 16;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic [STAMP_W-1:0]      TICK_MAX = '1;

  logic clk = 1'b0;
  logic rst;

  int mismatches;
  int pending;
  int hits;
  int fills;
  int evictions;

  int stall_asked  = 0;
  int stall_served = 0;
  int sent         = 0;
  bit tx_gapless   = 1'b0;

  logic [STAMP_W-1:0]      tick_now;
  logic signed [KEY_W-1:0] hist_x [HIST_DEPTH];
  logic signed [KEY_W-1:0] hist_z [HIST_DEPTH];
  int                      hist_n = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  tcache_req_if req_ch (clk);
  tcache_rsp_if rsp_ch (clk);

  tile_cache_lru_timestamp #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  tcache_access_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) access_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .mismatches(mismatches),
    .pending   (pending),
    .hits      (hits),
    .fills     (fills),
    .evictions (evictions)
  );

  // Gap after a request: mostly none, sometimes short, rarely long.
  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_gapless || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(30, 100);
  endfunction

  // Offers one request and holds it until the cache takes it.
  task automatic send_access(input logic signed [KEY_W-1:0] kx,
                             input logic signed [KEY_W-1:0] kz,
                             input logic [STAMP_W-1:0] tk);
    int gap;
    gap = next_gap();
    req_ch.valid <= 1'b1;
    req_ch.key_x <= kx;
    req_ch.key_z <= kz;
    req_ch.tick  <= tk;
    do @(posedge clk); while (!req_ch.ready);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hist_x[hist_n % HIST_DEPTH] = kx;
    hist_z[hist_n % HIST_DEPTH] = kz;
    hist_n++;
    sent++;
  endtask

  // Keys come mostly from a small grid and recent history, so that hits,
  // fills and evictions all occur; the rest are fully random.
  task automatic pick_key(output logic signed [KEY_W-1:0] kx,
                          output logic signed [KEY_W-1:0] kz);
    int roll;
    int idx;
    roll = $urandom_range(0, 99);
    if (roll < 50 || hist_n == 0) begin
      kx = KEY_W'(int'($urandom_range(0, 11)) - 6);
      kz = KEY_W'(int'($urandom_range(0, 11)) - 6);
    end else if (roll < 80) begin
      idx = (hist_n - 1 - int'($urandom_range(0, HIST_DEPTH - 1)));
      if (idx < 0) idx = 0;
      kx = hist_x[idx % HIST_DEPTH];
      kz = hist_z[idx % HIST_DEPTH];
    end else begin
      kx = $urandom();
      kz = $urandom();
    end
  endtask

  // Steady ticks with repeats give stamp ties; the jumpy style also throws
  // in arbitrary values and ticks that go backwards.
  task automatic advance_tick(input bit jumpy);
    int roll;
    roll = $urandom_range(0, 99);
    if (jumpy && roll < 20) tick_now = STAMP_W'($urandom());
    else if (jumpy && roll < 30) tick_now = tick_now - STAMP_W'($urandom_range(1, 50));
    else tick_now = tick_now + STAMP_W'($urandom_range(0, 3));
  endtask

  task automatic send_random(input int count, input bit jumpy);
    logic signed [KEY_W-1:0] kx;
    logic signed [KEY_W-1:0] kz;
    repeat (count) begin
      pick_key(kx, kz);
      advance_tick(jumpy);
      send_access(kx, kz, tick_now);
    end
  endtask

  // Response side: random short and long stalls, calm stretches, and the
  // long hold-off when the stimulus asks for one.
  initial begin
    int idle_left;
    int calm_left;
    int roll;
    idle_left = 0;
    calm_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (stall_served < stall_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_served++;
      end else if (idle_left > 0) begin
        rsp_ch.ready <= 1'b0;
        idle_left--;
        @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 10) idle_left = $urandom_range(1, 3);
          else if (roll < 12) idle_left = $urandom_range(20, 60);
          else if (roll == 12) calm_left = $urandom_range(100, 300);
        end
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.key_x <= '0;
    req_ch.key_z <= '0;
    req_ch.tick  <= '0;
    tick_now = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: key extremes, a hit, partial key matches, a backward stamp.
    send_access('0, '0, '0);
    send_access('0, '0, 31'd1);
    send_access(KEY_MIN, KEY_MAX, TICK_MAX);
    send_access(KEY_MAX, KEY_MIN, '0);
    send_access(-32'sd1, -32'sd1, 31'd5);
    send_access(-32'sd1, '0, 31'd5);
    send_access('0, -32'sd1, 31'd5);
    send_access(KEY_MIN, KEY_MAX, 31'd3);
    send_access(32'sh5555_5555, 32'shAAAA_AAAA, 31'h2AAA_AAAA);
    send_access(32'shAAAA_AAAA, 32'sh5555_5555, 31'h5555_5555);
    send_access(-32'sd1, -32'sd1, '0);
    send_access(KEY_MAX, KEY_MAX, 31'd1);
    send_access(KEY_MIN, KEY_MIN, 31'd2);
    tick_now = 31'd10;

    // Random traffic with steady ticks, filling the cache and evicting.
    send_random(250, 1'b0);

    // Long response stall while requests keep coming, so the input backs up.
    stall_asked <= stall_asked + 1;
    tx_gapless = 1'b1;
    send_random(30, 1'b0);
    tx_gapless = 1'b0;

    // Sender pause until every outstanding response has been delivered; the checker's
    // outstanding count is registered, so it shows the last acceptance only at the next edge.
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random traffic with jumpy ticks, then a back-to-back burst.
    send_random(250, 1'b1);
    tx_gapless = 1'b1;
    send_random(110, 1'b0);
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d hits, %0d fills, %0d of them evictions.",
             sent, hits, fills, evictions);
    $display("Included one long response stall, one drain pause and %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tile_cache_lru_timestamp regression: pass");
    end else begin
      $display("tile_cache_lru_timestamp regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #4_000_000;
    $display("tile_cache_lru_timestamp regression: fail");
    $finish;
  end

endmodule
